// ===== src/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// Shared constants, codes and types of the interpolating sample player.
// ----------------------------------------------------------------------------
package isp_pkg;

  // store geometry
  localparam int MAX_FRAMES   = 32768;
  localparam int NUM_CHANNELS = 2;
  localparam int FRAME_AW     = $clog2(MAX_FRAMES);
  localparam int CH_AW        = $clog2(NUM_CHANNELS);
  localparam int STORE_AW     = CH_AW + FRAME_AW;
  localparam int SAMPLE_W     = 16;

  // register and field widths
  localparam int LEN_W   = 16;
  localparam int CHN_W   = 2;
  localparam int LEVEL_W = 16;
  localparam int SPEED_W = 24;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int KIND_W  = 3;
  localparam int CFG_W   = 24;
  localparam int CFG_AW  = 3;

  // shared multiplier widths
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RND_W  = 18;

  localparam logic [LEN_W-1:0]   MAX_LEN     = LEN_W'(MAX_FRAMES);
  localparam logic [LEVEL_W-1:0] UNITY_LEVEL = 16'h8000;

  // input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 3'd0,
    KIND_RENDER  = 3'd1,
    KIND_PLAY    = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_RESTART = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_LENGTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CHANNELS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LEVEL    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SPEED    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LOOP     = 3'd4;

  // multiply-and-round operations
  typedef enum logic {
    MAC_INTERP = 1'b0,
    MAC_SCALE  = 1'b1
  } mac_op_t;

  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_ctl_t;

endpackage

// ===== src/isp_store.sv =====
// ----------------------------------------------------------------------------
// isp_store
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isp_store import isp_pkg::*; (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [STORE_AW-1:0]        wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [STORE_AW-1:0]        rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [2**STORE_AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/isp_mac.sv =====
// ----------------------------------------------------------------------------
// isp_mac
// Shared signed multiplier with registered product and rounding shift.
// ----------------------------------------------------------------------------
module isp_mac import isp_pkg::*; (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [RND_W-1:0] rnd
);

  localparam logic signed [PROD_W-1:0] HALF_INTERP = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] HALF_SCALE  = PROD_W'(16384);

  logic signed [PROD_W-1:0] prod;
  mac_op_t                  op_q;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;

  // product register
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= a * b;
      op_q <= ctl.op;
    end
  end

  // round to nearest, floor of the biased value
  always_comb begin
    case (op_q)
      MAC_INTERP: begin
        biased  = prod + HALF_INTERP;
        shifted = biased >>> 16;
      end
      MAC_SCALE: begin
        biased  = prod + HALF_SCALE;
        shifted = biased >>> 15;
      end
      default: begin
        biased  = prod;
        shifted = prod;
      end
    endcase
  end

  assign rnd = shifted[RND_W-1:0];

endmodule

// ===== src/interpolating_sample_player.sv =====
// ----------------------------------------------------------------------------
// interpolating_sample_player
// Sample playback with linear interpolation, level scaling and saturating mix.
// ----------------------------------------------------------------------------
// Each accepted item yields one result item; the block takes no new item until
// it is through with the last one. A render item that plays a frame runs
// longest, as the single store read port and the one shared multiplier serve
// both channels in turn (two reads, an interpolation multiply and a level
// multiply per channel); a render item while stopped does not use them. A
// finished result sits in an output register; it moves there only once the
// previous result has been taken, until then the sequencer holds in its finish
// state. The next item is taken in as soon as the block is idle.
module interpolating_sample_player import isp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_write_enable,
  input  logic [CFG_AW-1:0]          cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [FRAME_AW-1:0]        load_index,
  input  logic [CH_AW-1:0]           load_channel,
  input  logic signed [SAMPLE_W-1:0] load_value,
  input  logic signed [SAMPLE_W-1:0] mix_in_left,
  input  logic signed [SAMPLE_W-1:0] mix_in_right,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] mix_out_left,
  output logic signed [SAMPLE_W-1:0] mix_out_right,
  output logic                       playing,
  output logic [LEN_W-1:0]           position_index
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EXEC = 9'b000000010,
    ST_RD1  = 9'b000000100,
    ST_RD2  = 9'b000001000,
    ST_MUL1 = 9'b000010000,
    ST_INT  = 9'b000100000,
    ST_MUL2 = 9'b001000000,
    ST_SUM  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [LEN_W-1:0]   sample_length;
  logic [CHN_W-1:0]   sample_channels;
  logic [LEVEL_W-1:0] level;
  logic [SPEED_W-1:0] speed;
  logic               loop_enable;

  // playback state
  logic [POS_W-1:0] position;
  logic             play;

  // captured item
  logic [KIND_W-1:0]          kind_q;
  logic [FRAME_AW-1:0]        load_index_q;
  logic [CH_AW-1:0]           load_channel_q;
  logic signed [SAMPLE_W-1:0] load_value_q;
  logic signed [SAMPLE_W-1:0] mix_l_q;
  logic signed [SAMPLE_W-1:0] mix_r_q;

  // render working registers
  logic [FRAME_AW-1:0]        idx1;
  logic [FRAME_AW-1:0]        idx2;
  logic [FRAC_W-1:0]          frac;
  logic                       ch_q;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] interp;
  logic signed [SAMPLE_W-1:0] res_l;
  logic signed [SAMPLE_W-1:0] res_r;

  // datapath wires
  logic [LEN_W-1:0]           len_eff;
  logic                       loaded;
  logic [LEN_W-1:0]           pidx;
  logic                       at_end;
  logic                       wrap;
  logic                       do_render;
  logic [LEN_W-1:0]           cur16;
  logic [LEN_W-1:0]           nxt16;
  logic [POS_W-1:0]           pos_base;
  logic [LEVEL_W-1:0]         lv;
  logic [CH_AW-1:0]           src_ch;
  logic                       in_take;
  logic                       out_free;

  logic                       st_wr_en;
  logic [STORE_AW-1:0]        st_wr_addr;
  logic [STORE_AW-1:0]        st_rd_addr;
  logic signed [SAMPLE_W-1:0] st_rd_data;

  mac_ctl_t                   mac_ctl;
  logic signed [MUL_W-1:0]    mac_a;
  logic signed [MUL_W-1:0]    mac_b;
  logic signed [RND_W-1:0]    mac_rnd;

  logic signed [RND_W-1:0]    interp_sum;
  logic signed [SAMPLE_W-1:0] mix_sel;
  logic signed [RND_W:0]      total;
  logic signed [SAMPLE_W-1:0] sat;

  // effective settings
  assign len_eff = (sample_length > MAX_LEN) ? MAX_LEN : sample_length;
  assign loaded  = (len_eff != '0);
  assign lv      = (level > UNITY_LEVEL) ? UNITY_LEVEL : level;
  assign src_ch  = CH_AW'(ch_q && (sample_channels >= 2'd2));

  // end-of-sample decision for a render item
  assign pidx      = position[POS_W-1:FRAC_W];
  assign at_end    = (pidx >= (len_eff - 16'd1));
  assign wrap      = at_end && loop_enable;
  assign do_render = play && loaded && (!at_end || loop_enable);
  assign cur16     = wrap ? '0 : pidx;
  assign nxt16     = cur16 + 16'd1;
  assign pos_base  = wrap ? '0 : position;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // sample store
  assign st_wr_en   = (state == ST_EXEC) && (kind_q == KIND_LOAD);
  assign st_wr_addr = {load_channel_q, load_index_q};
  assign st_rd_addr = (state == ST_RD1) ? {src_ch, idx1} : {src_ch, idx2};

  isp_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (load_value_q),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // shared multiplier operands
  always_comb begin
    mac_ctl.en = (state == ST_MUL1) || (state == ST_MUL2);
    mac_ctl.op = (state == ST_MUL2) ? MAC_SCALE : MAC_INTERP;
    if (state == ST_MUL2) begin
      mac_a = MUL_W'(interp);
      mac_b = $signed({1'b0, lv});
    end else begin
      mac_a = MUL_W'(st_rd_data) - MUL_W'(s1);
      mac_b = $signed({1'b0, frac});
    end
  end

  isp_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .rnd (mac_rnd)
  );

  // interpolation and saturating mix
  assign interp_sum = RND_W'(s1) + mac_rnd;
  assign mix_sel    = ch_q ? mix_r_q : mix_l_q;
  assign total      = (RND_W + 1)'(mix_sel) + (RND_W + 1)'(mac_rnd);

  always_comb begin
    if (total > 19'sd32767) begin
      sat = 16'sh7fff;
    end else if (total < -19'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = total[SAMPLE_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_take) state_next = ST_EXEC;
      ST_EXEC: begin
        if (kind_q == KIND_RENDER && do_render) begin
          state_next = ST_RD1;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_MUL1;
      ST_MUL1: state_next = ST_INT;
      ST_INT:  state_next = ST_MUL2;
      ST_MUL2: state_next = ST_SUM;
      ST_SUM:  state_next = ch_q ? ST_FIN : ST_RD1;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      position        <= '0;
      play            <= 1'b0;
      sample_length   <= '0;
      sample_channels <= 2'd1;
      level           <= UNITY_LEVEL;
      speed           <= 24'h010000;
      loop_enable     <= 1'b0;
    end else begin
      state <= state_next;

      // result handshake
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // configuration writes
      if (cfg_write_enable) begin
        unique case (cfg_index)
          REG_LENGTH:   sample_length   <= cfg_data[LEN_W-1:0];
          REG_CHANNELS: sample_channels <= cfg_data[CHN_W-1:0];
          REG_LEVEL:    level           <= cfg_data[LEVEL_W-1:0];
          REG_SPEED:    speed           <= cfg_data[SPEED_W-1:0];
          REG_LOOP:     loop_enable     <= cfg_data[0];
          default: ;
        endcase
      end

      // playback state update
      if (state == ST_EXEC) begin
        unique case (kind_q)
          KIND_LOAD: begin
            position <= '0;
            play     <= 1'b0;
          end
          KIND_RENDER: begin
            if (play && loaded) begin
              if (do_render) begin
                position <= pos_base + POS_W'(speed);
              end else begin
                play <= 1'b0;
              end
            end
          end
          KIND_PLAY:    if (loaded) play <= 1'b1;
          KIND_STOP:    if (loaded) play <= 1'b0;
          KIND_RESTART: begin
            if (loaded) begin
              position <= '0;
              play     <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q         <= kind;
      load_index_q   <= load_index;
      load_channel_q <= load_channel;
      load_value_q   <= load_value;
      mix_l_q        <= mix_in_left;
      mix_r_q        <= mix_in_right;
    end
    unique case (state)
      ST_EXEC: begin
        ch_q <= 1'b0;
        idx1 <= cur16[FRAME_AW-1:0];
        idx2 <= (nxt16 < len_eff) ? nxt16[FRAME_AW-1:0] : '0;
        frac <= pos_base[FRAC_W-1:0];
        if (kind_q == KIND_RENDER) begin
          res_l <= mix_l_q;
          res_r <= mix_r_q;
        end else begin
          res_l <= '0;
          res_r <= '0;
        end
      end
      ST_RD2: s1     <= st_rd_data;
      ST_INT: interp <= interp_sum[SAMPLE_W-1:0];
      ST_SUM: begin
        ch_q <= 1'b1;
        if (ch_q) begin
          res_r <= sat;
        end else begin
          res_l <= sat;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          mix_out_left   <= res_l;
          mix_out_right  <= res_r;
          playing        <= play;
          position_index <= position[POS_W-1:FRAC_W];
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // an accepted item is decoded in the next cycle
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_EXEC)
    else $error("accepted item not decoded");

  // a waiting result holds the sequencer in the finish state
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_valid && out_stall |=> state == ST_FIN)
    else $error("result overwritten while waiting");

  // left channel is followed by the right channel
  a_ch_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM && !ch_q |=> state == ST_RD1 && ch_q)
    else $error("channel sequence broken");

  // the shared multiplier is used only in its two steps
  a_mac_use: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.en |-> state == ST_MUL1 || state == ST_MUL2)
    else $error("multiplier started outside its steps");
`endif

endmodule

// ===== test/sample_player_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_player_checker
// Watches the configuration port and both item channels of the sample player,
// keeps its own copy of the player state, works out every result item and
// compares each delivered result field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module sample_player_checker import isp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [CFG_AW-1:0]          cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [FRAME_AW-1:0]        load_index,
  input  logic [CH_AW-1:0]           load_channel,
  input  logic signed [SAMPLE_W-1:0] load_value,
  input  logic signed [SAMPLE_W-1:0] mix_in_left,
  input  logic signed [SAMPLE_W-1:0] mix_in_right,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] mix_out_left,
  input  logic signed [SAMPLE_W-1:0] mix_out_right,
  input  logic                       playing,
  input  logic [LEN_W-1:0]           position_index,
  output int                         failures,
  output int                         pending,
  output int                         frames_mixed,
  output int                         loop_wraps,
  output int                         end_stops
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       playing;
    logic [LEN_W-1:0]           pos;
  } player_out_t;

  // shadow of the player
  logic signed [SAMPLE_W-1:0] sample_mem [NUM_CHANNELS][MAX_FRAMES];
  logic [POS_W-1:0]   read_pos;
  logic               play_on;
  logic [LEN_W-1:0]   len_reg;
  logic [CHN_W-1:0]   chan_reg;
  logic [LEVEL_W-1:0] level_reg;
  logic [SPEED_W-1:0] speed_reg;
  logic               loop_on;

  player_out_t due_outputs [$];
  int items_in;
  int results_out;

  assign pending = items_in - results_out;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, results_out, msg);
    failures++;
  endtask

  // interpolate one channel, apply level, add to the mix and saturate
  function automatic logic signed [SAMPLE_W-1:0] mix_voice(
    input logic signed [SAMPLE_W-1:0] mix, input int src, input int i1, input int i2,
    input int frac);
    longint s1, s2, acc, interp, lv, scaled, sum;
    s1 = sample_mem[src][i1];
    s2 = sample_mem[src][i2];
    acc = s1 * (65536 - frac) + s2 * frac + 32768;
    interp = acc >>> 16;
    lv = (level_reg > UNITY_LEVEL) ? UNITY_LEVEL : level_reg;
    scaled = (interp * lv + 16384) >>> 15;
    sum = longint'(mix) + scaled;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return sum[SAMPLE_W-1:0];
  endfunction

  // advance the shadow state by one input item and queue its result
  task automatic play_item(input logic [KIND_W-1:0] k, input logic [FRAME_AW-1:0] idx,
                           input logic [CH_AW-1:0] ch, input logic signed [SAMPLE_W-1:0] val,
                           input logic signed [SAMPLE_W-1:0] ml,
                           input logic signed [SAMPLE_W-1:0] mr);
    int len, chans, pidx, nidx, frac;
    bit render;
    player_out_t o;
    len = (len_reg > MAX_LEN) ? MAX_FRAMES : int'(len_reg);
    chans = (chan_reg < 1) ? 1 : ((chan_reg > NUM_CHANNELS) ? NUM_CHANNELS : int'(chan_reg));
    o.left = '0;
    o.right = '0;
    case (k)
      KIND_LOAD: begin
        sample_mem[ch][idx] = val;
        read_pos = '0;
        play_on = 1'b0;
      end
      KIND_RENDER: begin
        o.left = ml;
        o.right = mr;
        if (play_on && len > 0) begin
          pidx = read_pos[POS_W-1:FRAC_W];
          frac = read_pos[FRAC_W-1:0];
          render = 1'b1;
          // end of sample: wrap with zero fraction or stop
          if (pidx >= len - 1) begin
            if (loop_on) begin
              read_pos = '0;
              pidx = 0;
              frac = 0;
              loop_wraps++;
            end else begin
              play_on = 1'b0;
              render = 1'b0;
              end_stops++;
            end
          end
          if (render) begin
            nidx = (pidx + 1 < len) ? pidx + 1 : 0;
            o.left = mix_voice(ml, 0, pidx, nidx, frac);
            o.right = mix_voice(mr, (chans > 1) ? 1 : 0, pidx, nidx, frac);
            read_pos = read_pos + speed_reg;
            frames_mixed++;
          end
        end
      end
      KIND_PLAY: begin
        if (len > 0) play_on = 1'b1;
      end
      KIND_STOP: begin
        if (len > 0) play_on = 1'b0;
      end
      KIND_RESTART: begin
        if (len > 0) begin
          read_pos = '0;
          play_on = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.playing = play_on;
    o.pos = read_pos[POS_W-1:FRAC_W];
    due_outputs.push_back(o);
  endtask

  // compare a delivered result with the oldest one owed
  task automatic check_result();
    player_out_t want;
    if (due_outputs.size() == 0) begin
      report_mismatch("result item with nothing outstanding");
      return;
    end
    want = due_outputs.pop_front();
    if (mix_out_left !== want.left)
      report_mismatch($sformatf("mix_out_left %0d, want %0d", mix_out_left, want.left));
    if (mix_out_right !== want.right)
      report_mismatch($sformatf("mix_out_right %0d, want %0d", mix_out_right, want.right));
    if (playing !== want.playing)
      report_mismatch($sformatf("playing %0b, want %0b", playing, want.playing));
    if (position_index !== want.pos)
      report_mismatch($sformatf("position_index %0d, want %0d", position_index, want.pos));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      read_pos = '0;
      play_on = 1'b0;
      len_reg = '0;
      chan_reg = 2'd1;
      level_reg = UNITY_LEVEL;
      speed_reg = 24'h010000;
      loop_on = 1'b0;
      due_outputs.delete();
      failures = 0;
      frames_mixed = 0;
      loop_wraps = 0;
      end_stops = 0;
      items_in <= 0;
      results_out <= 0;
    end else begin
      // register writes
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_LENGTH:   len_reg = cfg_data[LEN_W-1:0];
          REG_CHANNELS: chan_reg = cfg_data[CHN_W-1:0];
          REG_LEVEL:    level_reg = cfg_data[LEVEL_W-1:0];
          REG_SPEED:    speed_reg = cfg_data[SPEED_W-1:0];
          REG_LOOP:     loop_on = cfg_data[0];
          default: begin
          end
        endcase
      end
      // results first so a fresh item never answers for an older result
      if (out_valid && !out_stall) begin
        check_result();
        results_out <= results_out + 1;
      end
      if (in_valid && !in_stall) begin
        play_item(kind, load_index, load_channel, load_value, mix_in_left, mix_in_right);
        items_in <= items_in + 1;
      end
    end
  end

endmodule

// ===== test/interpolating_sample_player_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interpolating_sample_player_test
// Drives load, render and transport items into the sample player under
// several register settings and flow-control patterns; a checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module interpolating_sample_player_test import isp_pkg::*;;

  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 50;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write_enable = 1'b0;
  logic [CFG_AW-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [KIND_W-1:0]          kind = '0;
  logic [FRAME_AW-1:0]        load_index = '0;
  logic [CH_AW-1:0]           load_channel = '0;
  logic signed [SAMPLE_W-1:0] load_value = '0;
  logic signed [SAMPLE_W-1:0] mix_in_left = '0;
  logic signed [SAMPLE_W-1:0] mix_in_right = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] mix_out_left;
  logic signed [SAMPLE_W-1:0] mix_out_right;
  logic                       playing;
  logic [LEN_W-1:0]           position_index;

  int failures;
  int pending;
  int frames_mixed;
  int loop_wraps;
  int end_stops;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit filled [NUM_CHANNELS][MAX_FRAMES];

  interpolating_sample_player i_dut (.*);

  sample_player_checker i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // no item moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no item moved for %0d cycles, %0d results outstanding", QUIET_LIMIT, pending);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // present one item, with random idle cycles ahead of it
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [FRAME_AW-1:0] idx,
                           input logic [CH_AW-1:0] ch, input logic [SAMPLE_W-1:0] val,
                           input logic [SAMPLE_W-1:0] ml, input logic [SAMPLE_W-1:0] mr);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    load_index <= idx;
    load_channel <= ch;
    load_value <= val;
    mix_in_left <= ml;
    mix_in_right <= mr;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_word(input int idx, input int ch, input logic [SAMPLE_W-1:0] val);
    filled[ch][idx] = 1'b1;
    send_item(KIND_LOAD, FRAME_AW'(idx), CH_AW'(ch), val, rand_sample(), rand_sample());
  endtask

  task automatic render_frame(input logic [SAMPLE_W-1:0] ml, input logic [SAMPLE_W-1:0] mr);
    send_item(KIND_RENDER, FRAME_AW'($urandom), CH_AW'($urandom), rand_sample(), ml, mr);
  endtask

  task automatic send_cmd(input logic [KIND_W-1:0] k);
    send_item(k, FRAME_AW'($urandom), CH_AW'($urandom), rand_sample(), rand_sample(),
              rand_sample());
  endtask

  // hold the sender until every result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [LEN_W-1:0] len, input logic [CHN_W-1:0] chans,
                           input logic [LEVEL_W-1:0] lvl, input logic [SPEED_W-1:0] spd,
                           input logic lp);
    drain();
    write_reg(REG_LENGTH, CFG_W'(len));
    write_reg(REG_CHANNELS, CFG_W'(chans));
    write_reg(REG_LEVEL, CFG_W'(lvl));
    write_reg(REG_SPEED, CFG_W'(spd));
    write_reg(REG_LOOP, CFG_W'(lp));
  endtask

  // make sure frames 0..n-1 hold data on both channels before playing them
  task automatic fill_prefix(input int n);
    for (int idx = 0; idx < n; idx++) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (!filled[ch][idx]) load_word(idx, ch, rand_sample());
      end
    end
  endtask

  initial begin
    int n, r, idx, run_len;
    logic [LEVEL_W-1:0] lvl;
    logic [SPEED_W-1:0] spd;
    longint pos;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // nothing loaded: render passes the mix, transport and undefined kinds do nothing
    render_frame(16'h7fff, 16'h8000);
    send_cmd(KIND_PLAY);
    send_cmd(KIND_STOP);
    send_cmd(KIND_RESTART);
    for (int k = KIND_RESTART + 1; k < 2 ** KIND_W; k++) send_cmd(KIND_W'(k));

    // two frames of full-scale samples, half speed, stops at the end
    load_word(0, 0, 16'h8000);
    load_word(0, 1, 16'h7fff);
    load_word(1, 0, 16'h7fff);
    load_word(1, 1, 16'h8000);
    configure(LEN_W'(2), 2'd2, UNITY_LEVEL, 24'h008000, 1'b0);
    send_cmd(KIND_PLAY);
    render_frame(16'h8000, 16'h7fff);
    render_frame(16'h8000, 16'h8000);
    render_frame(16'h0000, 16'h0000);
    render_frame(16'h1234, 16'h4321);
    send_cmd(KIND_STOP);
    send_cmd(KIND_RESTART);
    render_frame(16'h7fff, 16'h7fff);
    send_cmd(KIND_STOP);
    render_frame(16'h0001, 16'hffff);

    // full-size store at top speed: load only the frames the position visits
    idle_pct = 10;
    stall_pct = 10;
    spd = {SPEED_W{1'b1}};
    pos = 0;
    run_len = 0;
    while ((pos >> FRAC_W) < MAX_FRAMES - 1) begin
      idx = int'(pos >> FRAC_W);
      if (!filled[0][idx]) load_word(idx, 0, rand_sample());
      if (!filled[0][idx + 1]) load_word(idx + 1, 0, rand_sample());
      pos = pos + spd;
      run_len++;
    end
    configure(MAX_LEN, 2'd1, LEVEL_W'($urandom_range(0, 65535)), spd, 1'b1);
    send_cmd(KIND_RESTART);
    repeat (run_len + 3) render_frame(rand_sample(), rand_sample());
    // length register beyond the store size, no loop
    drain();
    write_reg(REG_LENGTH, CFG_W'(16'hffff));
    write_reg(REG_LOOP, CFG_W'(1'b0));
    send_cmd(KIND_RESTART);
    repeat (run_len + 3) render_frame(rand_sample(), rand_sample());

    // random phases over register settings and flow-control patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case (p % 6)
        0: n = 1;
        1: n = 0;
        default: n = $urandom_range(2, 48);
      endcase
      case (p % 4)
        0: lvl = '0;
        1: lvl = {LEVEL_W{1'b1}};
        2: lvl = UNITY_LEVEL;
        default: lvl = LEVEL_W'($urandom);
      endcase
      case (p % 5)
        0: spd = '0;
        1: spd = {SPEED_W{1'b1}};
        2: spd = 24'h010000;
        3: spd = SPEED_W'($urandom_range(1, 24'h03ffff));
        default: spd = SPEED_W'($urandom);
      endcase
      fill_prefix(n);
      configure(LEN_W'(n), CHN_W'((p + 1) % 4), lvl, spd, 1'((p / 2) % 2));
      send_cmd(KIND_RESTART);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          render_frame(rand_sample(), rand_sample());
        end else if (r < 76) begin
          send_cmd(KIND_PLAY);
        end else if (r < 80) begin
          send_cmd(KIND_STOP);
        end else if (r < 85) begin
          send_cmd(KIND_RESTART);
        end else if (r < 93) begin
          // rewrite a frame in use, or any frame of the store
          if ($urandom_range(0, 1) == 0) begin
            load_word($urandom_range(0, (n > 0) ? n - 1 : 0), $urandom_range(0, 1),
                      rand_sample());
          end else begin
            load_word($urandom_range(0, MAX_FRAMES - 1), $urandom_range(0, 1),
                      rand_sample());
          end
        end else begin
          send_cmd(KIND_W'($urandom_range(KIND_RESTART + 1, 2 ** KIND_W - 1)));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d items: %0d frames mixed, %0d loop wraps, %0d end-of-sample stops",
             items_sent, frames_mixed, loop_wraps, end_stops);
    $display("lengths 0 to beyond the store, all channel, level, speed and loop extremes");
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
